>>> design/lnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_pkg
// Shared types and constants of the layer normalisation block.
// ----------------------------------------------------------------------------
package lnf_pkg;

  localparam int MaxDimDefault = 64;
  localparam logic [15:0] EpsilonReset = 16'd1;
  localparam logic [23:0] RstdMax = 24'hFFFFFF;

  typedef enum logic [0:0] {
    REG_EPSILON = 1'b0,
    REG_NONE    = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN,
    ST_VAR_RD,
    ST_VAR_ACC,
    ST_VAR_DIV,
    ST_RECIP,
    ST_ROOT,
    ST_EMIT_RD,
    ST_EMIT_MUL1,
    ST_EMIT_MUL2,
    ST_EMIT_OUT
  } state_t;

endpackage

>>> design/lnf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lnf_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/lnf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnf_divider #(
  parameter int NumW = 49,
  parameter int DenW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quo
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] shreg;
  logic [DenW:0]   rem;
  logic [DenW-1:0] dreg;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  // One shift-subtract step.
  always_comb begin
    trial = {rem[DenW-1:0], shreg[NumW-1]};
    diff  = trial - {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        shreg <= num;
        dreg  <= den;
        rem   <= '0;
        cnt   <= CntW'(NumW);
      end else if (busy) begin
        if (!diff[DenW]) begin
          rem   <= diff;
          shreg <= {shreg[NumW-2:0], 1'b1};
        end else begin
          rem   <= trial;
          shreg <= {shreg[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = shreg;

endmodule

>>> design/lnf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lnf_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [49:0] arg,
  output logic        done,
  output logic [24:0] root
);

  logic [49:0] rad;
  logic [26:0] rem;
  logic [24:0] res;
  logic [4:0]  cnt;
  logic        busy;
  logic [26:0] trial;
  logic [26:0] cand;

  // Each step brings down two radicand bits and tries res*4+1.
  always_comb begin
    trial = {rem[24:0], rad[49:48]};
    cand  = trial - {res, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rad  <= arg;
        rem  <= '0;
        res  <= '0;
        cnt  <= 5'd25;
      end else if (busy) begin
        rad <= {rad[47:0], 2'b00};
        if (!cand[26]) begin
          rem <= cand;
          res <= {res[23:0], 1'b1};
        end else begin
          rem <= trial;
          res <= {res[23:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res;

endmodule

>>> design/layer_norm_forward.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_norm_forward
// Layer normalisation of rows of up to MaxDim Q8.8 elements.
// ----------------------------------------------------------------------------
// Elements are written into three row memories, one item per cycle. On the
// item marked row_end the block stalls input and works on the buffered row of
// n elements: a mean division, a variance pass over the row, a variance
// division, a reciprocal division, a square root (skipped when variance plus
// epsilon is zero), and an emit pass that takes each element through the
// memory read port, a registered multiply and a combinational wide multiply.
// One output register parts the output from the sequencer; the emit waits
// while it is stalled. Elements beyond MaxDim are dropped and the row's
// results are flagged.
module layer_norm_forward
  import lnf_pkg::*;
#(
  parameter int MaxDim = lnf_pkg::MaxDimDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] x_value,
  input  logic signed [15:0] gain_value,
  input  logic signed [15:0] bias_value,
  input  logic               row_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] y_value,
  output logic signed [15:0] row_mean,
  output logic [23:0]        row_rstd,
  output logic               too_long,
  output logic               last
);

  localparam int AddrW = $clog2(MaxDim);
  localparam int CntW  = $clog2(MaxDim + 1);

  // Configuration register.
  logic [15:0] epsilon;
  reg_index_t  reg_sel;
  assign pready  = 1'b1;
  assign reg_sel = paddr[2] ? REG_NONE : REG_EPSILON;
  always_comb begin
    case (reg_sel)
      REG_EPSILON: prdata = {16'd0, epsilon};
      default:     prdata = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EpsilonReset;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_EPSILON) begin
      epsilon <= pwdata[15:0];
    end
  end

  state_t state, state_next;
  logic              in_acc;
  logic [CntW-1:0]   count;
  logic [AddrW-1:0]  idx;
  logic signed [22:0] sum;
  logic              ovf;
  logic signed [15:0] mean;
  logic [38:0]       sq;
  logic [32:0]       var_v;
  logic [23:0]       rstd;
  logic signed [16:0] d_reg;
  logic signed [15:0] g_reg, b_reg;
  logic signed [32:0] gd;
  logic signed [58:0] prod;
  logic              pending;

  logic [15:0] x_rd, g_rd, b_rd;
  logic        wr_en;
  logic [AddrW-1:0] rd_addr;

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (count < CntW'(MaxDim));
  // The variance pass reads one entry ahead of the one being accumulated.
  assign rd_addr  = (state == ST_VAR_ACC) ? idx + 1'b1 : idx;

  lnf_ram #(.Width(16), .Depth(MaxDim)) u_x_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(count[AddrW-1:0]), .wr_data(x_value),
    .rd_addr(rd_addr), .rd_data(x_rd));
  lnf_ram #(.Width(16), .Depth(MaxDim)) u_g_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(count[AddrW-1:0]), .wr_data(gain_value),
    .rd_addr(rd_addr), .rd_data(g_rd));
  lnf_ram #(.Width(16), .Depth(MaxDim)) u_b_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(count[AddrW-1:0]), .wr_data(bias_value),
    .rd_addr(rd_addr), .rd_data(b_rd));

  // Shared divider: mean, variance and reciprocal.
  logic        div_start, div_done;
  logic [48:0] div_num, div_quo;
  logic [32:0] div_den;
  lnf_divider #(.NumW(49), .DenW(33)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo));

  logic        sq_start, sq_done;
  logic [24:0] sq_root;
  lnf_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .arg({1'b0, div_quo}),
    .done(sq_done), .root(sq_root));

  // Row counter and sum use the incoming element before mean division.
  logic [CntW-1:0]    count_in;
  logic signed [22:0] sum_in;
  assign count_in = wr_en ? count + 1'b1 : count;
  assign sum_in   = wr_en ? sum + 23'(x_value) : sum;

  // Mean numerator 2*sum+n, made non-negative by a bias of 2*n*2^15.
  logic signed [25:0] mnum;
  logic [25:0]        mbias;
  assign mbias = 26'(count_in) << 16;
  assign mnum  = 26'(sum_in) * 26'sd2 + 26'(count_in) + $signed(mbias);

  logic started;
  logic emit_last;
  assign emit_last = (CntW'(idx) == count - 1'b1);

  // Divider operand for the recurrence below.
  logic [32:0] v_full;
  assign v_full = var_v + 33'(epsilon);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:     if (in_acc && row_end) state_next = ST_MEAN;
      ST_MEAN:     if (div_done) state_next = ST_VAR_RD;
      ST_VAR_RD:   state_next = ST_VAR_ACC;
      ST_VAR_ACC:  if (emit_last) state_next = ST_VAR_DIV;
                   else state_next = ST_VAR_ACC;
      ST_VAR_DIV:  if (div_done && started) state_next = ST_RECIP;
      ST_RECIP:    if (div_done && started) begin
                     state_next = (v_full == 33'd0) ? ST_EMIT_RD : ST_ROOT;
                   end
      ST_ROOT:     if (sq_done) state_next = ST_EMIT_RD;
      ST_EMIT_RD:  state_next = ST_EMIT_MUL1;
      ST_EMIT_MUL1: state_next = ST_EMIT_MUL2;
      ST_EMIT_MUL2: state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: if (!pending || !out_stall) begin
                     state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
                   end
      default:     state_next = ST_LOAD;
    endcase
  end

  // Divider operand selection and divider and square-root start strobes.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    case (state)
      ST_LOAD: begin
        div_start = in_acc && row_end;
      end
      ST_VAR_DIV: begin
        div_num = 49'(sq);
        div_den = 33'(count);
      end
      ST_RECIP: begin
        div_num = 49'h1_0000_0000_0000;
        div_den = v_full;
      end
      ST_ROOT: begin
        sq_start = 1'b0;
      end
      default: begin
      end
    endcase
    if (state == ST_MEAN) begin
      div_num = 49'(mnum);
      div_den = 33'(count_in) << 1;
    end
    if (state == ST_LOAD) begin
      div_num = 49'(mnum);
      div_den = 33'(count_in) << 1;
    end
    if ((state == ST_VAR_DIV || state == ST_RECIP) && !started) begin
      div_start = 1'b1;
    end
    if (state == ST_RECIP && div_done && started) begin
      sq_start = (v_full != 0);
    end
  end

  logic signed [16:0] d_now;
  assign d_now = $signed({x_rd[15], x_rd}) - 17'(mean);

  logic signed [34:0] yr;
  logic signed [17:0] ys;
  assign yr = 35'(prod >>> 24) + 35'(b_reg);
  always_comb begin
    if (yr > 35'sd32767) ys = 18'sd32767;
    else if (yr < -35'sd32768) ys = -18'sd32768;
    else ys = 18'(yr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      sum       <= '0;
      ovf       <= 1'b0;
      idx       <= '0;
      started   <= 1'b0;
      pending   <= 1'b0;
    end else begin
      state <= state_next;
      // The output register fills on an emit and drains when accepted.
      if (state == ST_EMIT_OUT && (!pending || !out_stall)) pending <= 1'b1;
      else if (!out_stall) pending <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            count <= count_in;
            sum   <= sum_in;
            if (!wr_en) ovf <= 1'b1;
          end
          idx <= '0;
        end
        ST_MEAN: begin
          if (div_done) begin
            mean <= 16'(div_quo[24:0] - 25'd32768);
            sq   <= '0;
          end
        end
        ST_VAR_ACC: begin
          sq <= sq + 39'(d_now * d_now);
          if (!emit_last) idx <= idx + 1'b1;
        end
        ST_VAR_DIV: begin
          started <= !(div_done && started);
          if (div_done && started) begin
            var_v <= 33'(div_quo);
          end
        end
        ST_RECIP: begin
          started <= !(div_done && started);
          idx     <= '0;
          if (div_done && started && v_full == 33'd0) begin
            rstd <= RstdMax;
          end
        end
        ST_ROOT: begin
          if (sq_done) rstd <= sq_root[24] ? RstdMax : sq_root[23:0];
          idx <= '0;
        end
        ST_EMIT_MUL1: begin
          d_reg <= d_now;
          g_reg <= g_rd;
          b_reg <= b_rd;
        end
        ST_EMIT_MUL2: begin
          gd <= 33'(g_reg) * 33'(d_reg);
        end
        ST_EMIT_OUT: begin
          if (!pending || !out_stall) begin
            y_value <= ys[15:0];
            row_mean <= mean;
            row_rstd <= rstd;
            too_long <= ovf;
            last     <= emit_last;
            if (emit_last) begin
              count <= '0;
              sum   <= '0;
              ovf   <= 1'b0;
              idx   <= '0;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Product with rounding bias, one wide multiply after the registered g*d.
  always_comb prod = 59'(gd) * $signed({35'd0, rstd}) + 59'sd8388608;

  assign out_valid = pending;

endmodule
